// ----- rtl/field_statistics_accumulator_unit_defines.svh -----
// Assertion macros shared by the statistics accumulator RTL.
// Depends on nothing; included by the modules that assert.
`ifndef FIELD_STATISTICS_ACCUMULATOR_UNIT_DEFINES_SVH
`define FIELD_STATISTICS_ACCUMULATOR_UNIT_DEFINES_SVH
// implication checked every cycle outside reset
`define FSA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define FSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/fsa_pkg.sv -----
// Shared types and constants for the statistics accumulator.
// No dependencies.
package fsa_pkg;
  localparam int SumW = 40;
  localparam int SqW  = 62;
  localparam int VarW = 79;

  // closed set handed from the accumulator to the finisher
  typedef struct packed {
    logic [15:0]          count;
    logic signed [23:0]   minimum;
    logic signed [23:0]   maximum;
    logic signed [SumW-1:0] sum;
    logic [SqW-1:0]       sqsum;
    logic                 overflow;
  } set_t;
endpackage

// ----- rtl/fsa_accum.sv -----
// Front part: accepts samples one per cycle while in_stall is low, and keeps
// the running totals. Uses fsa_pkg. Emits one closed set per last item.
module fsa_accum #(
  parameter int MAX_COUNT    = 65535,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [23:0]  in_sample,
  input  logic                in_has_value,
  input  logic                in_last,
  output logic                set_valid,
  input  logic                set_stall,
  output fsa_pkg::set_t       set_data
);
  logic [15:0]                 cnt_r;
  logic signed [23:0]          min_r, max_r;
  logic signed [fsa_pkg::SumW-1:0] sum_r;
  logic [fsa_pkg::SqW-1:0]     sq_r;
  logic                        ovf_r;
  logic                        set_valid_r;
  fsa_pkg::set_t               set_r;

  logic signed [SAMPLE_WIDTH-1:0] raw;
  logic signed [23:0]          v;
  logic [23:0]                 mag;
  logic                        take, acc;
  logic [15:0]                 cnt_nxt;
  logic signed [23:0]          min_nxt, max_nxt;
  logic signed [fsa_pkg::SumW-1:0] sum_nxt;
  logic [fsa_pkg::SqW-1:0]     sq_nxt;
  logic                        ovf_nxt;

  assign in_stall = set_valid_r && set_stall;
  assign take     = in_valid && !in_stall;
  assign raw      = in_sample[SAMPLE_WIDTH-1:0];
  assign v        = 24'(raw);
  assign mag      = v[23] ? 24'(-v) : 24'(v);
  assign acc      = take && in_has_value && (32'(cnt_r) < 32'(MAX_COUNT));

  always_comb begin
    cnt_nxt = cnt_r;
    min_nxt = min_r;
    max_nxt = max_r;
    sum_nxt = sum_r;
    sq_nxt  = sq_r;
    ovf_nxt = ovf_r;
    if (acc) begin
      cnt_nxt = cnt_r + 16'd1;
      min_nxt = (cnt_r == 16'd0 || v < min_r) ? v : min_r;
      max_nxt = (cnt_r == 16'd0 || v > max_r) ? v : max_r;
      sum_nxt = sum_r + fsa_pkg::SumW'(v);
      sq_nxt  = sq_r + fsa_pkg::SqW'(mag * mag);
    end else if (take && in_has_value) begin
      ovf_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; min_r <= '0; max_r <= '0; sum_r <= '0; sq_r <= '0; ovf_r <= 1'b0;
      set_valid_r <= 1'b0;
    end else begin
      if (take && in_last) begin
        set_valid_r    <= 1'b1;
        set_r.count    <= cnt_nxt;
        set_r.minimum  <= min_nxt;
        set_r.maximum  <= max_nxt;
        set_r.sum      <= sum_nxt;
        set_r.sqsum    <= sq_nxt;
        set_r.overflow <= ovf_nxt;
        cnt_r <= '0; min_r <= '0; max_r <= '0; sum_r <= '0; sq_r <= '0; ovf_r <= 1'b0;
      end else begin
        if (set_valid_r && !set_stall) set_valid_r <= 1'b0;
        cnt_r <= cnt_nxt; min_r <= min_nxt; max_r <= max_nxt;
        sum_r <= sum_nxt; sq_r <= sq_nxt; ovf_r <= ovf_nxt;
      end
    end
  end

  assign set_valid = set_valid_r;
  assign set_data  = set_r;

`include "field_statistics_accumulator_unit_defines.svh"
  `FSA_ASSERT_IMPL(a_cnt_limit, 1'b1, 32'(cnt_r) <= 32'(MAX_COUNT))
  `FSA_ASSERT_NEXT(a_clear, take && in_last, cnt_r == 16'd0 && !ovf_r)
  `FSA_ASSERT_IMPL(a_order, cnt_r != 16'd0, min_r <= max_r)
endmodule

// ----- rtl/fsa_finish.sv -----
// Back part: computes mean and deviation of a closed set by shift-subtract
// division and an iterative square root. Uses fsa_pkg.
module fsa_finish (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 set_valid,
  output logic                 set_stall,
  input  fsa_pkg::set_t        set_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [15:0]          out_count,
  output logic signed [23:0]   out_minimum,
  output logic signed [23:0]   out_maximum,
  output logic signed [23:0]   out_mean,
  output logic [23:0]          out_deviation,
  output logic                 out_overflow
);
  localparam int VW = fsa_pkg::VarW;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_MULQ = 7'b0000010, S_MULS = 7'b0000100,
    S_DIVM = 7'b0001000, S_DIVV = 7'b0010000, S_SQRT = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t                 st_r;
  fsa_pkg::set_t          s_r;
  logic [39:0]            smag_r;
  logic [VW-1:0]          acc_r;      // count*sqsum, minuend of the variance numerator
  logic [VW-1:0]          mcand_r;
  logic [31:0]            mplier_r;
  logic [VW:0]            rem_r;
  logic [VW-1:0]          quo_r;
  logic [6:0]             step_r;
  logic [31:0]            dsor_r;
  logic                   neg_r;
  logic [63:0]            x_r, res_r, one_r;
  logic [23:0]            mean_r, dev_r;
  logic                   ov_r;
  logic [VW-1:0]          num_r;
  logic [VW-1:0]          ssq_r;

  logic [VW:0]            rsh;
  logic [VW-1:0]          dbit_src;
  logic                   ge;

  assign set_stall = (st_r != S_IDLE);
  assign dbit_src  = (st_r == S_DIVM) ? VW'(smag_r) : num_r;
  assign rsh       = {rem_r[VW-1:0], dbit_src[7'(VW-1) - step_r]};
  assign ge        = rsh >= (VW+1)'(dsor_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      unique case (st_r)
        S_IDLE: if (set_valid) begin
          s_r      <= set_data;
          smag_r   <= set_data.sum[39] ? 40'(-set_data.sum) : 40'(set_data.sum);
          neg_r    <= set_data.sum[39];
          mcand_r  <= VW'(set_data.sqsum);
          mplier_r <= 32'(set_data.count);
          acc_r    <= '0;
          step_r   <= '0;
          st_r     <= (set_data.count == 16'd0) ? S_DONE : S_MULQ;
          mean_r   <= '0;
          dev_r    <= '0;
        end
        // shift-add multiply, one multiplier bit per cycle
        S_MULQ: begin
          if (mplier_r[0]) acc_r <= acc_r + mcand_r;
          if (mplier_r[31:1] == '0) begin
            st_r    <= S_MULS;
            mcand_r <= VW'(smag_r);
            ssq_r   <= '0;
            step_r  <= '0;
          end else begin
            mcand_r  <= mcand_r << 1;
            mplier_r <= mplier_r >> 1;
          end
        end
        S_MULS: begin
          if (smag_r[6'(step_r)]) ssq_r <= ssq_r + mcand_r;
          if (step_r == 7'd39) begin
            st_r   <= S_DIVM;
            step_r <= 7'(VW - 40);
            rem_r  <= '0;
            quo_r  <= '0;
            dsor_r <= 32'(s_r.count);
          end else begin
            mcand_r <= mcand_r << 1;
            step_r  <= step_r + 7'd1;
          end
        end
        // restoring division, one quotient bit per cycle
        S_DIVM, S_DIVV: begin
          if (step_r == 7'(VW-1)) begin
            if (st_r == S_DIVM) begin
              mean_r <= neg_r ? 24'(-({quo_r[VW-2:0], ge})) : 24'({quo_r[VW-2:0], ge});
              num_r  <= (acc_r >= ssq_r) ? acc_r - ssq_r : '0;
              dsor_r <= 32'(s_r.count) * 32'(s_r.count);
              rem_r  <= '0;
              quo_r  <= '0;
              step_r <= '0;
              st_r   <= S_DIVV;
            end else begin
              x_r   <= 64'({quo_r[VW-2:0], ge});
              res_r <= '0;
              one_r <= 64'd1 << 62;
              st_r  <= S_SQRT;
            end
          end else begin
            rem_r  <= ge ? rsh - (VW+1)'(dsor_r) : rsh;
            quo_r  <= {quo_r[VW-2:0], ge};
            step_r <= step_r + 7'd1;
          end
        end
        // digit-by-digit square root, two radicand bits per cycle
        S_SQRT: begin
          if (one_r == '0) begin
            dev_r <= (res_r > 64'hFFFFFF) ? 24'hFFFFFF : res_r[23:0];
            st_r  <= S_DONE;
          end else begin
            if (x_r >= res_r + one_r) begin
              x_r   <= x_r - (res_r + one_r);
              res_r <= (res_r >> 1) + one_r;
            end else begin
              res_r <= res_r >> 1;
            end
            one_r <= one_r >> 2;
          end
        end
        S_DONE: if (!out_valid || !out_stall) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
      if (st_r == S_DONE && (!out_valid || !out_stall)) ov_r <= 1'b1;
      else if (out_valid && !out_stall) ov_r <= 1'b0;
    end
  end

  logic [15:0]        oc_r;
  logic signed [23:0] omin_r, omax_r, omean_r;
  logic [23:0]        odev_r;
  logic               oovf_r;
  always_ff @(posedge clk) begin
    if (st_r == S_DONE && (!out_valid || !out_stall)) begin
      oc_r    <= s_r.count;
      omin_r  <= s_r.minimum;
      omax_r  <= s_r.maximum;
      omean_r <= mean_r;
      odev_r  <= dev_r;
      oovf_r  <= s_r.overflow;
    end
  end

  assign out_valid     = ov_r;
  assign out_count     = oc_r;
  assign out_minimum   = omin_r;
  assign out_maximum   = omax_r;
  assign out_mean      = omean_r;
  assign out_deviation = odev_r;
  assign out_overflow  = oovf_r;

`include "field_statistics_accumulator_unit_defines.svh"
  `FSA_ASSERT_IMPL(a_busy_stall, st_r != S_IDLE, set_stall)
  `FSA_ASSERT_NEXT(a_out_rise, st_r == S_DONE && !out_stall, out_valid)
  `FSA_ASSERT_IMPL(a_onehot, 1'b1, $onehot(st_r))
endmodule

// ----- rtl/field_statistics_accumulator_unit.sv -----
// Statistics accumulator: samples accumulate at one item per cycle while in_stall is
// low. A last item closes its set into the accumulator's set register, from which
// the finisher takes it when idle; for an empty set the finisher goes straight to
// its done state. The set register lets the next set accumulate; input stalls
// while a closed set waits there for the busy finisher.
// Synchronous active-low reset clears totals and all valid flags.
module field_statistics_accumulator_unit #(
  parameter int MAX_COUNT    = 65535,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] in_sample,
  input  logic               in_has_value,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_count,
  output logic signed [23:0] out_minimum,
  output logic signed [23:0] out_maximum,
  output logic signed [23:0] out_mean,
  output logic [23:0]        out_deviation,
  output logic               out_overflow
);
  logic          set_valid, set_stall;
  fsa_pkg::set_t set_data;

  fsa_accum #(.MAX_COUNT(MAX_COUNT), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_accum (
    .clk, .rst_n, .in_valid, .in_stall, .in_sample, .in_has_value, .in_last,
    .set_valid, .set_stall, .set_data
  );

  fsa_finish u_finish (
    .clk, .rst_n, .set_valid, .set_stall, .set_data,
    .out_valid, .out_stall, .out_count, .out_minimum, .out_maximum,
    .out_mean, .out_deviation, .out_overflow
  );
endmodule
